/* sv/g2e_pkg.sv */
`default_nettype none

package g2e_pkg;

	// latency of the rounding multiplier, in clock cycles
	localparam int MUL_LAT = 4;

	// cordic datapath width and width of a clamped sine or cosine, both q40
	localparam int CW = 43;
	localparam int TW = 42;

	localparam logic signed [30:0] LAT_LIMIT  = 31'sd754974720;
	localparam logic signed [30:0] LAT_MIN    = -31'sd754974720;
	localparam logic signed [31:0] LON_LIMIT  = 32'sd1509949440;
	localparam logic signed [31:0] LON_MIN    = -32'sd1509949440;
	localparam logic signed [31:0] LON_HALF   = 32'sd754974720;
	localparam logic signed [31:0] LON_HALF_N = -32'sd754974720;

	localparam logic [63:0] EQ_RADIUS_MM = 64'd6378137000;
	localparam logic [63:0] E2_NUM       = 64'd669437999014;
	localparam logic [63:0] FIVE_POW14   = 64'd6103515625;

	localparam logic signed [CW-1:0] CORDIC_GAIN_Q40 = 43'sd667681663043;
	localparam logic signed [CW-1:0] ONE_Q40         = 43'sh100_0000_0000;

	typedef struct packed {
		logic              invalid;
		logic              flip;
		logic signed [37:0] alt;
	} side_t;

	typedef struct packed {
		logic signed [TW-1:0] cl;
		logic signed [TW-1:0] sl;
		logic signed [TW-1:0] co;
		logic signed [TW-1:0] so;
	} trig_t;

	// pi/4 in q62 from machin's formula, truncated series terms
	function automatic logic signed [63:0] pi_quarter_q62();
		logic [63:0]        p5;
		logic [63:0]        p239;
		logic signed [63:0] s5;
		logic signed [63:0] s239;
		logic signed [63:0] t;
		logic [63:0]        Den;
		p5   = (64'd1 << 62) / 64'd5;
		p239 = (64'd1 << 62) / 64'd239;
		s5   = '0;
		s239 = '0;
		for (int k = 0; k < 40; k++) begin
			Den = 64'(2 * k + 1);
			if (p5 != 64'd0) begin
				t  = signed'(p5 / Den);
				s5 = k[0] ? s5 - t : s5 + t;
				p5 = p5 / 64'd25;
			end
			if (p239 != 64'd0) begin
				t    = signed'(p239 / Den);
				s239 = k[0] ? s239 - t : s239 + t;
				p239 = p239 / 64'd57121;
			end
		end
		return (s5 <<< 2) - s239;
	endfunction

	// floor(e2 * 2^62) by long division against 5^14
	function automatic logic signed [63:0] e2_q62();
		logic [63:0] q;
		logic [63:0] r;
		q = E2_NUM / FIVE_POW14;
		r = E2_NUM % FIVE_POW14;
		for (int i = 0; i < 48; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= FIVE_POW14) begin
				r = r - FIVE_POW14;
				q = q | 64'd1;
			end
		end
		return signed'(q);
	endfunction

	localparam logic signed [63:0] PQ_Q62 = pi_quarter_q62();
	localparam logic signed [57:0] C62_Q62 = 58'(PQ_Q62 / 45);
	localparam logic signed [62:0] E2_Q62 = 63'(e2_q62());
	localparam logic signed [62:0] ONE_MINUS_E2_Q62 = 63'((64'sd1 <<< 62) - e2_q62());

	// atan(2^-i) in q40, rounded from a q62 series
	function automatic logic signed [CW-1:0] atan_stage_q40(input int i,
			input logic signed [63:0] pq);
		logic signed [63:0] s;
		logic signed [63:0] t;
		logic signed [63:0] Den;
		int                 sh;
		s = '0;
		if (i == 0) begin
			return CW'((pq + (64'sd1 <<< 21)) >>> 22);
		end
		for (int k = 0; k < 32; k++) begin
			sh = 62 - (2 * k + 1) * i;
			if (sh >= 0) begin
				Den = 64'(2 * k + 1);
				t   = (64'sd1 <<< sh) / Den;
				s   = k[0] ? s - t : s + t;
			end
		end
		return CW'((s + (64'sd1 <<< 21)) >>> 22);
	endfunction

	// limit a cordic output to [-1, 1]
	function automatic logic signed [TW-1:0] clamp_unit(input logic signed [CW-1:0] v);
		if (v > ONE_Q40) begin
			return TW'(ONE_Q40);
		end else if (v < -ONE_Q40) begin
			return TW'(-ONE_Q40);
		end
		return TW'(v);
	endfunction

endpackage

`default_nettype wire

/* sv/g2e_mulr.sv */
`default_nettype none

// signed multiply, rescale by 2^SH rounding half away from zero, saturate to WO bits
module g2e_mulr #(
	parameter int WA = 32,
	parameter int WB = 32,
	parameter int SH = 32,
	parameter int WO = 32
) (
	input  logic                 clk,
	input  logic signed [WA-1:0] a,
	input  logic signed [WB-1:0] b,
	output logic signed [WO-1:0] y
);

	localparam logic [127:0] RND     = 128'd1 << (SH - 1);
	localparam logic [127:0] POS_LIM = (128'd1 << (WO - 1)) - 128'd1;
	localparam logic [127:0] NEG_LIM = 128'd1 << (WO - 1);

	logic [WA:0]   abs_a;
	logic [WB:0]   abs_b;
	logic          neg_s1, neg_s2, neg_s3;
	logic [63:0]   ma_s1, mb_s1;
	logic [63:0]   ll_s2, lh_s2, hl_s2, hh_s2;
	logic [127:0]  sum_s3;
	logic [127:0]  m_c;
	logic [WO-1:0] y_c;

	// magnitudes
	assign abs_a = a[WA-1] ? ((~{a[WA-1], a}) + 1'b1) : {1'b0, a};
	assign abs_b = b[WB-1] ? ((~{b[WB-1], b}) + 1'b1) : {1'b0, b};

	always_ff @(posedge clk) begin
		neg_s1 <= a[WA-1] ^ b[WB-1];
		ma_s1  <= 64'(abs_a);
		mb_s1  <= 64'(abs_b);
	end

	// partial products of 32-bit halves
	always_ff @(posedge clk) begin
		neg_s2 <= neg_s1;
		ll_s2  <= ma_s1[31:0] * mb_s1[31:0];
		lh_s2  <= ma_s1[31:0] * mb_s1[63:32];
		hl_s2  <= ma_s1[63:32] * mb_s1[31:0];
		hh_s2  <= ma_s1[63:32] * mb_s1[63:32];
	end

	// full product plus rounding half
	always_ff @(posedge clk) begin
		neg_s3 <= neg_s2;
		sum_s3 <= {64'd0, ll_s2} + ({64'd0, lh_s2} << 32) + ({64'd0, hl_s2} << 32)
			+ {hh_s2, 64'd0} + RND;
	end

	// shift, saturate and restore sign
	always_comb begin
		m_c = sum_s3 >> SH;
		if (neg_s3) begin
			y_c = (m_c > NEG_LIM) ? WO'(NEG_LIM) : WO'(~m_c + 128'd1);
		end else begin
			y_c = (m_c > POS_LIM) ? WO'(POS_LIM) : WO'(m_c);
		end
	end

	always_ff @(posedge clk) begin
		y <= y_c;
	end

endmodule

`default_nettype wire

/* sv/geodetic_to_ecef_core.sv */
`default_nettype none

// WGS84 geodetic to ECEF conversion. One word is taken on any clock edge with start high
// (busy is always low), and its result is shown for one cycle with done high; results
// leave in the order the words came in and cannot be held off. The pipeline is made up
// of the two parallel cordic pipelines (one stage per iteration), the 32-stage square
// root, the 33-stage divider for the prime-vertical radius and five multipliers in series.
// Out of range latitude or longitude gives input_invalid high and zero coordinates.
module geodetic_to_ecef_core #(
	parameter int CORDIC_STAGES = 28
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [30:0] lat_deg_q23,
	input  logic signed [31:0] lon_deg_q23,
	input  logic signed [37:0] alt_mm,
	output logic               done,
	output logic signed [37:0] ecef_x_mm,
	output logic signed [37:0] ecef_y_mm,
	output logic signed [37:0] ecef_z_mm,
	output logic               input_invalid
);

	localparam int CW = g2e_pkg::CW;
	localparam int TW = g2e_pkg::TW;
	localparam int NC = CORDIC_STAGES;
	localparam int ML = g2e_pkg::MUL_LAT;
	// depth of each pipeline point, counted from the input register
	localparam int K_TRIG = ML + NC + 1;
	localparam int K_D    = K_TRIG + 2 * ML + 1;
	localparam int K_R    = K_D + 33;
	localparam int K_N    = K_R + 33;
	localparam int K_Z    = K_N + ML + 2;
	localparam int K_F    = K_Z + ML;
	localparam int K_OUT  = K_F + 1;
	localparam int TD     = K_Z - K_TRIG;

	logic [K_F:0]        vld_s;
	g2e_pkg::side_t      side_s [0:K_F];
	g2e_pkg::trig_t      trig_s [0:TD];
	logic                invalid_c, flip_c;
	logic signed [31:0]  lon_c;
	logic signed [30:0]  lat_s0;
	logic signed [31:0]  lon_s0;
	logic signed [CW-1:0] theta [0:1];
	logic signed [CW-1:0] cx_s [0:NC-1][0:1];
	logic signed [CW-1:0] cy_s [0:NC-1][0:1];
	logic signed [CW-1:0] cz_s [0:NC-1][0:1];
	logic signed [TW-1:0] s2;
	logic signed [62:0]   em;
	logic [62:0]          sq_rem_s  [0:32];
	logic [31:0]          sq_root_s [0:32];
	logic [63:0]          dv_rem_s  [0:33];
	logic [31:0]          dv_den_s  [0:33];
	logic [32:0]          dv_q_s    [0:33];
	logic signed [58:0]   r20_s;
	logic signed [33:0]   n1_s;
	logic signed [59:0]   pm;
	logic signed [55:0]   zm;
	logic signed [59:0]   p_s;
	logic signed [59:0]   zr_s;
	logic signed [37:0]   xm, ym, zmf;
	logic                 done_q, invalid_q;
	logic signed [37:0]   x_q, y_q, z_q;

	assign busy = 1'b0;

	// range check and longitude fold
	always_comb begin
		invalid_c = (lat_deg_q23 < g2e_pkg::LAT_MIN) || (lat_deg_q23 > g2e_pkg::LAT_LIMIT)
			|| (lon_deg_q23 < g2e_pkg::LON_MIN) || (lon_deg_q23 > g2e_pkg::LON_LIMIT);
		flip_c = 1'b0;
		lon_c  = lon_deg_q23;
		if (lon_deg_q23 > g2e_pkg::LON_HALF) begin
			lon_c  = lon_deg_q23 - g2e_pkg::LON_LIMIT;
			flip_c = 1'b1;
		end else if (lon_deg_q23 < g2e_pkg::LON_HALF_N) begin
			lon_c  = lon_deg_q23 + g2e_pkg::LON_LIMIT;
			flip_c = 1'b1;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[K_F-1:0], start};
		end
	end

	// input register and side band delay line
	always_ff @(posedge clk) begin
		lat_s0    <= lat_deg_q23;
		lon_s0    <= lon_c;
		side_s[0] <= '{invalid: invalid_c, flip: flip_c, alt: alt_mm};
		for (int k = 1; k <= K_F; k++) begin
			side_s[k] <= side_s[k-1];
		end
	end

	// degrees to radians
	g2e_mulr #(.WA(31), .WB(58), .SH(45), .WO(CW)) u_mul_lat (
		.clk(clk), .a(lat_s0), .b(g2e_pkg::C62_Q62), .y(theta[0])
	);
	g2e_mulr #(.WA(32), .WB(58), .SH(45), .WO(CW)) u_mul_lon (
		.clk(clk), .a(lon_s0), .b(g2e_pkg::C62_Q62), .y(theta[1])
	);

	// rotation-mode cordic, one stage per iteration, latitude and longitude side by side
	for (genvar i = 0; i < NC; i++) begin : g_cordic
		localparam logic signed [CW-1:0] ATAN = g2e_pkg::atan_stage_q40(i, g2e_pkg::PQ_Q62);
		logic signed [CW-1:0] xi [0:1];
		logic signed [CW-1:0] yi [0:1];
		logic signed [CW-1:0] zi [0:1];
		if (i == 0) begin : g_first
			assign xi[0] = g2e_pkg::CORDIC_GAIN_Q40;
			assign xi[1] = g2e_pkg::CORDIC_GAIN_Q40;
			assign yi[0] = '0;
			assign yi[1] = '0;
			assign zi[0] = theta[0];
			assign zi[1] = theta[1];
		end else begin : g_next
			assign xi[0] = cx_s[i-1][0];
			assign xi[1] = cx_s[i-1][1];
			assign yi[0] = cy_s[i-1][0];
			assign yi[1] = cy_s[i-1][1];
			assign zi[0] = cz_s[i-1][0];
			assign zi[1] = cz_s[i-1][1];
		end
		always_ff @(posedge clk) begin
			for (int u = 0; u < 2; u++) begin
				if (zi[u] >= 0) begin
					cx_s[i][u] <= xi[u] - (yi[u] >>> i);
					cy_s[i][u] <= yi[u] + (xi[u] >>> i);
					cz_s[i][u] <= zi[u] - ATAN;
				end else begin
					cx_s[i][u] <= xi[u] + (yi[u] >>> i);
					cy_s[i][u] <= yi[u] - (xi[u] >>> i);
					cz_s[i][u] <= zi[u] + ATAN;
				end
			end
		end
	end

	// clamp, undo the longitude fold, delay line for the trig values
	always_ff @(posedge clk) begin
		trig_s[0].cl <= g2e_pkg::clamp_unit(cx_s[NC-1][0]);
		trig_s[0].sl <= g2e_pkg::clamp_unit(cy_s[NC-1][0]);
		if (side_s[K_TRIG-1].flip) begin
			trig_s[0].co <= -g2e_pkg::clamp_unit(cx_s[NC-1][1]);
			trig_s[0].so <= -g2e_pkg::clamp_unit(cy_s[NC-1][1]);
		end else begin
			trig_s[0].co <= g2e_pkg::clamp_unit(cx_s[NC-1][1]);
			trig_s[0].so <= g2e_pkg::clamp_unit(cy_s[NC-1][1]);
		end
		for (int k = 1; k <= TD; k++) begin
			trig_s[k] <= trig_s[k-1];
		end
	end

	// sin^2 of latitude, then e2 sin^2
	g2e_mulr #(.WA(TW), .WB(TW), .SH(40), .WO(TW)) u_mul_s2 (
		.clk(clk), .a(trig_s[0].sl), .b(trig_s[0].sl), .y(s2)
	);
	g2e_mulr #(.WA(63), .WB(TW), .SH(40), .WO(63)) u_mul_e2 (
		.clk(clk), .a(g2e_pkg::E2_Q62), .b(s2), .y(em)
	);

	// 1 - e2 sin^2 in q62
	always_ff @(posedge clk) begin
		sq_rem_s[0]  <= (63'd1 << 62) - unsigned'(em);
		sq_root_s[0] <= '0;
	end

	// square root, one root bit per stage
	for (genvar j = 0; j < 32; j++) begin : g_sqrt
		localparam int K = 31 - j;
		logic [64:0] test;
		assign test = ({33'd0, sq_root_s[j]} << (K + 1)) + (65'd1 << (2 * K));
		always_ff @(posedge clk) begin
			if ({2'b00, sq_rem_s[j]} >= test) begin
				sq_rem_s[j+1]  <= sq_rem_s[j] - 63'(test);
				sq_root_s[j+1] <= sq_root_s[j] | (32'd1 << K);
			end else begin
				sq_rem_s[j+1]  <= sq_rem_s[j];
				sq_root_s[j+1] <= sq_root_s[j];
			end
		end
	end

	// numerator a * 2^31 plus half the divisor for rounding
	always_ff @(posedge clk) begin
		dv_den_s[0] <= (sq_root_s[32] == 32'd0) ? 32'd1 : sq_root_s[32];
		dv_rem_s[0] <= (g2e_pkg::EQ_RADIUS_MM << 31)
			+ 64'(((sq_root_s[32] == 32'd0) ? 32'd1 : sq_root_s[32]) >> 1);
		dv_q_s[0]   <= '0;
	end

	// restoring divider, one quotient bit per stage
	for (genvar j = 0; j < 33; j++) begin : g_div
		localparam int K = 32 - j;
		logic [64:0] trial;
		assign trial = {33'd0, dv_den_s[j]} << K;
		always_ff @(posedge clk) begin
			dv_den_s[j+1] <= dv_den_s[j];
			if ({1'b0, dv_rem_s[j]} >= trial) begin
				dv_rem_s[j+1] <= dv_rem_s[j] - 64'(trial);
				dv_q_s[j+1]   <= dv_q_s[j] | (33'd1 << K);
			end else begin
				dv_rem_s[j+1] <= dv_rem_s[j];
				dv_q_s[j+1]   <= dv_q_s[j];
			end
		end
	end

	// radius plus height in q20
	always_ff @(posedge clk) begin
		r20_s <= 59'(signed'({6'd0, dv_q_s[33]}) + 39'(side_s[K_N].alt)) <<< 20;
		n1_s  <= signed'({1'b0, dv_q_s[33]});
	end

	g2e_mulr #(.WA(59), .WB(TW), .SH(40), .WO(60)) u_mul_p (
		.clk(clk), .a(r20_s), .b(trig_s[K_N+1-K_TRIG].cl), .y(pm)
	);
	g2e_mulr #(.WA(34), .WB(63), .SH(42), .WO(56)) u_mul_zn (
		.clk(clk), .a(n1_s), .b(g2e_pkg::ONE_MINUS_E2_Q62), .y(zm)
	);

	// polar radius term plus height
	always_ff @(posedge clk) begin
		p_s  <= pm;
		zr_s <= 60'(zm) + (60'(side_s[K_Z-1].alt) <<< 20);
	end

	g2e_mulr #(.WA(60), .WB(TW), .SH(60), .WO(38)) u_mul_x (
		.clk(clk), .a(p_s), .b(trig_s[TD].co), .y(xm)
	);
	g2e_mulr #(.WA(60), .WB(TW), .SH(60), .WO(38)) u_mul_y (
		.clk(clk), .a(p_s), .b(trig_s[TD].so), .y(ym)
	);
	g2e_mulr #(.WA(60), .WB(TW), .SH(60), .WO(38)) u_mul_z (
		.clk(clk), .a(zr_s), .b(trig_s[TD].sl), .y(zmf)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= vld_s[K_F];
		end
	end

	always_ff @(posedge clk) begin
		invalid_q <= side_s[K_F].invalid;
		x_q       <= side_s[K_F].invalid ? '0 : xm;
		y_q       <= side_s[K_F].invalid ? '0 : ym;
		z_q       <= side_s[K_F].invalid ? '0 : zmf;
	end

	assign done          = done_q;
	assign input_invalid = invalid_q;
	assign ecef_x_mm     = x_q;
	assign ecef_y_mm     = y_q;
	assign ecef_z_mm     = z_q;

	// every accepted word comes out after the fixed latency
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##(K_OUT + 1) done)
		else $error("result strobe missing after fixed latency");

	// an invalid word carries zero coordinates
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && input_invalid |-> ecef_x_mm == '0 && ecef_y_mm == '0 && ecef_z_mm == '0)
		else $error("invalid word with non-zero coordinates");

	// the root feeding the divider stays near 2^31 so the quotient fits
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[K_R] |-> dv_den_s[0] >= 32'h4000_0000)
		else $error("square root out of range");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
`default_nettype none

module tb_top;

	localparam int STAGES = 28;
	localparam int LIMIT_CYCLES = 400000;
	localparam longint LAT_LIM = 64'sd754974720;
	localparam longint LON_LIM = 64'sd1509949440;
	localparam longint COORD_MAX = 64'sd137438953471;
	localparam longint COORD_MIN = -64'sd137438953472;
	localparam logic [63:0] EQ_RADIUS = 64'd6378137000;
	localparam logic [63:0] E2_DECIMAL = 64'd669437999014;
	localparam logic [63:0] POW5_14 = 64'd6103515625;

	typedef struct {
		logic signed [37:0] x;
		logic signed [37:0] y;
		logic signed [37:0] z;
		logic               inv;
	} coord_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic signed [30:0] lat_deg_q23 = '0;
	logic signed [31:0] lon_deg_q23 = '0;
	logic signed [37:0] alt_mm = '0;
	logic               busy;
	logic               done;
	logic signed [37:0] ecef_x_mm;
	logic signed [37:0] ecef_y_mm;
	logic signed [37:0] ecef_z_mm;
	logic               input_invalid;

	coord_t coord_q[$];
	longint pi_quarter;
	longint deg_to_rad;
	longint e2_fix;
	longint atan_tab[0:63];
	int     n_errors = 0;
	int     n_words = 0;
	int     n_results = 0;
	int     n_invalid = 0;
	int     n_cycles = 0;
	bit     no_idle = 1'b0;

	geodetic_to_ecef_core #(.CORDIC_STAGES(STAGES)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.lat_deg_q23(lat_deg_q23),
		.lon_deg_q23(lon_deg_q23),
		.alt_mm(alt_mm),
		.done(done),
		.ecef_x_mm(ecef_x_mm),
		.ecef_y_mm(ecef_y_mm),
		.ecef_z_mm(ecef_z_mm),
		.input_invalid(input_invalid)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// round(a * b / 2^sh), ties away from zero, saturated to 63 bits
	function automatic longint round_mul(input longint a, input longint b, input int sh);
		logic [127:0] prod;
		logic [63:0]  ua;
		logic [63:0]  ub;
		bit           neg;
		neg = (a < 0) != (b < 0);
		ua = a < 0 ? 64'(-a) : 64'(a);
		ub = b < 0 ? 64'(-b) : 64'(b);
		prod = {64'd0, ua} * {64'd0, ub};
		prod = (prod + (128'd1 << (sh - 1))) >> sh;
		if (prod > 128'h7fff_ffff_ffff_ffff)
			prod = 128'h7fff_ffff_ffff_ffff;
		return neg ? -longint'(prod[63:0]) : longint'(prod[63:0]);
	endfunction

	// atan(1/n) in q62 by its power series
	function automatic longint atan_recip(input longint n);
		logic [63:0] p;
		longint      s;
		longint      k;
		p = (64'd1 << 62) / 64'(n);
		s = 0;
		k = 0;
		while (p != 0) begin
			s = k[0] ? s - longint'(p / 64'(2 * k + 1)) : s + longint'(p / 64'(2 * k + 1));
			p = p / 64'(n * n);
			k++;
		end
		return s;
	endfunction

	// constants of the conversion, worked out once
	task automatic build_constants();
		logic [63:0] q;
		logic [63:0] r;
		longint      s;
		int          sh;
		pi_quarter = 4 * atan_recip(5) - atan_recip(239);
		deg_to_rad = pi_quarter / 45;
		q = E2_DECIMAL / POW5_14;
		r = E2_DECIMAL % POW5_14;
		for (int i = 0; i < 48; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= POW5_14) begin
				r = r - POW5_14;
				q = q | 64'd1;
			end
		end
		e2_fix = longint'(q);
		atan_tab[0] = (pi_quarter + (64'sd1 <<< 21)) >>> 22;
		for (int i = 1; i < 64; i++) begin
			s = 0;
			for (int k = 0; 62 - (2 * k + 1) * i >= 0; k++) begin
				sh = 62 - (2 * k + 1) * i;
				s = k[0] ? s - (64'sd1 <<< sh) / (2 * k + 1) : s + (64'sd1 <<< sh) / (2 * k + 1);
			end
			atan_tab[i] = (s + (64'sd1 <<< 21)) >>> 22;
		end
	endtask

	function automatic longint unit_clamp(input longint v);
		if (v > (64'sd1 <<< 40))
			return 64'sd1 <<< 40;
		if (v < -(64'sd1 <<< 40))
			return -(64'sd1 <<< 40);
		return v;
	endfunction

	// rotation-mode cordic, angle and outputs q40
	task automatic rotate(input longint theta, output longint c, output longint s);
		longint x;
		longint y;
		longint z;
		longint dx;
		longint dy;
		x = 64'sd667681663043;
		y = 0;
		z = theta;
		for (int i = 0; i < STAGES && i < 62; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tab[i];
			end else begin
				x += dx; y -= dy; z += atan_tab[i];
			end
		end
		c = unit_clamp(x);
		s = unit_clamp(y);
	endtask

	function automatic logic [63:0] root_floor(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [37:0] to_coord(input longint v);
		if (v > COORD_MAX)
			v = COORD_MAX;
		if (v < COORD_MIN)
			v = COORD_MIN;
		return v[37:0];
	endfunction

	// expected ecef position of one geodetic word
	task automatic ecef_of(input longint lat, input longint lon, input longint alt,
			output coord_t res);
		longint      cl, sl, co, so, s2, d, n, r20, p, zr;
		logic [63:0] root;
		bit          flip;
		res = '{x: '0, y: '0, z: '0, inv: 1'b1};
		flip = 1'b0;
		if (lat < -LAT_LIM || lat > LAT_LIM || lon < -LON_LIM || lon > LON_LIM)
			return;
		// wide longitude folded back by half a turn
		if (lon > LAT_LIM) begin
			lon -= LON_LIM; flip = 1'b1;
		end else if (lon < -LAT_LIM) begin
			lon += LON_LIM; flip = 1'b1;
		end
		rotate(round_mul(lat, deg_to_rad, 45), cl, sl);
		rotate(round_mul(lon, deg_to_rad, 45), co, so);
		if (flip) begin
			co = -co; so = -so;
		end
		// prime-vertical radius
		s2 = round_mul(sl, sl, 40);
		d = (64'sd1 <<< 62) - round_mul(e2_fix, s2, 40);
		if (d <= 0)
			d = 1;
		root = root_floor(64'(d));
		if (root == 0)
			root = 1;
		n = longint'(((EQ_RADIUS << 31) + root / 2) / root);
		r20 = n * 1048576 + alt * 1048576;
		p = round_mul(r20, cl, 40);
		zr = round_mul(n, (64'sd1 <<< 62) - e2_fix, 42) + alt * 1048576;
		res.x = to_coord(round_mul(p, co, 60));
		res.y = to_coord(round_mul(p, so, 60));
		res.z = to_coord(round_mul(zr, sl, 60));
		res.inv = 1'b0;
	endtask

	task automatic report(input string what, input longint got, input longint want);
		n_errors++;
		$display("mismatch %s: got %0d expected %0d (result %0d)", what, got, want, n_results);
	endtask

	// hand one word to the block and queue its expected position
	task automatic send_word(input longint lat, input longint lon, input longint alt);
		int     gap;
		coord_t res;
		gap = no_idle ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		lat_deg_q23 <= lat[30:0];
		lon_deg_q23 <= lon[31:0];
		alt_mm <= alt[37:0];
		@(posedge clk);
		while (busy)
			@(posedge clk);
		ecef_of(longint'(signed'(lat[30:0])), longint'(signed'(lon[31:0])),
			longint'(signed'(alt[37:0])), res);
		coord_q.push_back(res);
		n_words++;
	endtask

	task automatic drain();
		start <= 1'b0;
		while (coord_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic longint rand_alt_full();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return longint'(signed'(r[37:0]));
	endfunction

	function automatic longint rand_span(input longint lo, input longint hi);
		logic [63:0] r;
		r = {$urandom, $urandom};
		return lo + longint'(r % 64'(hi - lo + 1));
	endfunction

	// field extremes, range edges, wide longitude and saturation
	task automatic test_directed();
		longint alt_max;
		longint alt_min;
		alt_max = (64'sd1 <<< 37) - 1;
		alt_min = -(64'sd1 <<< 37);
		no_idle = 1'b1;
		send_word(0, 0, 0);
		send_word(LAT_LIM, 0, 0);
		send_word(-LAT_LIM, 0, 0);
		send_word(LAT_LIM / 2, LAT_LIM / 2, 1000000);
		send_word(0, LAT_LIM, 0);
		send_word(0, -LAT_LIM, 0);
		send_word(0, LAT_LIM + 1, 0);
		send_word(0, -LAT_LIM - 1, 0);
		send_word(0, LON_LIM, 0);
		send_word(0, -LON_LIM, 0);
		send_word(LAT_LIM + 1, 0, 0);
		send_word(-LAT_LIM - 1, 0, 0);
		send_word(0, LON_LIM + 1, 0);
		send_word(0, -LON_LIM - 1, 0);
		send_word(-(64'sd1 <<< 30), 0, 0);
		send_word((64'sd1 <<< 30) - 1, -(64'sd1 <<< 31), 0);
		send_word(0, (64'sd1 <<< 31) - 1, 0);
		send_word(0, 0, alt_max);
		send_word(0, LON_LIM, alt_max);
		send_word(LAT_LIM, 0, alt_max);
		send_word(-LAT_LIM, LON_LIM / 3, alt_min);
		send_word(0, LAT_LIM, alt_min);
		send_word(123456789, -987654321, -1000000000);
		no_idle = 1'b0;
	endtask

	// in-range positions, random spacing between words except every third run of 100, sent back to back
	task automatic test_random_valid(input int count);
		longint alt;
		for (int i = 0; i < count; i++) begin
			no_idle = (i / 100) % 3 == 2;
			case ($urandom_range(0, 3))
				0: alt = rand_alt_full();
				1: alt = rand_span(-64'sd1000000000, 64'sd100000000000);
				2: alt = rand_span(-100000, 10000000);
				default: alt = rand_span(-64'sd1000000000, 64'sd1000000000);
			endcase
			send_word(rand_span(-LAT_LIM, LAT_LIM), rand_span(-LON_LIM, LON_LIM), alt);
		end
		no_idle = 1'b0;
	endtask

	// any bit pattern on every field, about half of them out of range
	task automatic test_random_raw(input int count);
		for (int i = 0; i < count; i++)
			send_word(longint'(signed'(31'($urandom))), longint'(signed'(32'($urandom))),
				rand_alt_full());
	endtask

	// sender waits for the pipeline to empty between small bursts
	task automatic test_pause_drain();
		for (int b = 0; b < 3; b++) begin
			for (int i = 0; i < 5; i++)
				send_word(rand_span(-LAT_LIM, LAT_LIM), rand_span(-LON_LIM, LON_LIM),
					rand_span(-1000000, 1000000000));
			drain();
		end
	endtask

	// compare each finished word with the oldest prediction
	always @(posedge clk) begin
		coord_t want;
		if (arst_n && done) begin
			n_results++;
			if (coord_q.size() == 0) begin
				report("unexpected word", 0, 0);
			end else begin
				want = coord_q.pop_front();
				if (want.inv)
					n_invalid++;
				if (input_invalid !== want.inv)
					report("input_invalid", input_invalid, want.inv);
				if (ecef_x_mm !== want.x)
					report("ecef_x_mm", ecef_x_mm, want.x);
				if (ecef_y_mm !== want.y)
					report("ecef_y_mm", ecef_y_mm, want.y);
				if (ecef_z_mm !== want.z)
					report("ecef_z_mm", ecef_z_mm, want.z);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		n_cycles++;
		if (n_cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", n_cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		build_constants();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_pause_drain();
		test_random_valid(1400);
		test_random_raw(280);
		drain();
		repeat (STAGES + 150) @(posedge clk);
		$display("%0d words sent, %0d results checked, %0d of them flagged out of range",
			n_words, n_results, n_invalid);
		$display("covered range edges, wide longitude, saturation and random bit patterns");
		if (n_errors == 0 && coord_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

`default_nettype wire
